// ----- rtl/text_console_writer_defines.svh -----
// Assertion helpers for the text console writer.
// Every check runs on the rising edge of clk and is quiet while rst is high.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int TAB_WIDTH = 4;
  localparam int CELL_COUNT = ROWS * COLUMNS;

  // Field widths
  localparam int ROW_W     = 5;
  localparam int COL_W     = 7;
  localparam int CHAR_W    = 8;
  localparam int BG_W      = 3;
  localparam int FG_W      = 4;
  localparam int CELL_W    = 16;
  localparam int ADDR_W    = $clog2(CELL_COUNT);
  localparam int TAB_CNT_W = $clog2(TAB_WIDTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = FG_W;
  localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOREGROUND = 1'd1;

  // Character codes
  localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'd32;
  localparam logic [CHAR_W-1:0] LAST_PRINTABLE = 8'd126;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
  localparam logic [CHAR_W-1:0] TAB_CODE       = 8'd9;
  localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'd8;

  // Operation codes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Reset colors and the blank cell they give
  localparam logic [BG_W-1:0]   BG_RESET    = 3'd7;
  localparam logic [FG_W-1:0]   FG_RESET    = 4'd12;
  localparam logic [CELL_W-1:0] RESET_BLANK = {1'b0, BG_RESET, FG_RESET, SPACE_CODE};

  // Microprogram step addresses
  typedef enum logic [3:0] {
    U_CLEAR,
    U_FETCH,
    U_READ,
    U_PUT,
    U_TAB,
    U_NEWLINE,
    U_SCROLL,
    U_BACKSPACE,
    U_EMIT
  } upc_t;

  // Datapath actions
  typedef enum logic [3:0] {
    A_CLEAR,
    A_FETCH,
    A_READ,
    A_PUT,
    A_TAB,
    A_NEWLINE,
    A_BLANK,
    A_BACKSPACE,
    A_EMIT
  } act_t;

  // Branch conditions
  typedef enum logic [2:0] {
    C_TRUE,
    C_CLEAR_LAST,
    C_ROW_LAST,
    C_TAB_LAST,
    C_SCROLL,
    C_OUT_FREE,
    C_DISPATCH
  } cond_t;

  // One control word: action, branch condition, target when true, target when false
  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  jt;
    upc_t  jf;
  } uop_t;

  // Control store
  function automatic uop_t ucode(input upc_t pc);
    uop_t w;
    unique case (pc)
      U_CLEAR:     w = '{A_CLEAR,     C_CLEAR_LAST, U_FETCH,  U_CLEAR};
      U_FETCH:     w = '{A_FETCH,     C_DISPATCH,   U_FETCH,  U_FETCH};
      U_READ:      w = '{A_READ,      C_TRUE,       U_EMIT,   U_EMIT};
      U_PUT:       w = '{A_PUT,       C_TRUE,       U_EMIT,   U_EMIT};
      U_TAB:       w = '{A_TAB,       C_TAB_LAST,   U_EMIT,   U_TAB};
      U_NEWLINE:   w = '{A_NEWLINE,   C_SCROLL,     U_SCROLL, U_EMIT};
      U_SCROLL:    w = '{A_BLANK,     C_ROW_LAST,   U_EMIT,   U_SCROLL};
      U_BACKSPACE: w = '{A_BACKSPACE, C_TRUE,       U_EMIT,   U_EMIT};
      U_EMIT:      w = '{A_EMIT,      C_OUT_FREE,   U_FETCH,  U_EMIT};
      default:     w = '{A_FETCH,     C_DISPATCH,   U_FETCH,  U_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tcw_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one put or read operation per transaction
interface tcw_req_if import tcw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CHAR_W-1:0] char_code;
  logic [ROW_W-1:0]  read_row;
  logic [COL_W-1:0]  read_col;

  modport source (output valid, opcode, char_code, read_row, read_col, input ready);
  modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

// Response channel: cursor and read cell, one transaction per request
interface tcw_rsp_if import tcw_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  modport source (output valid, cursor_row, cursor_col, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cell_char, cell_attr, output ready);
endinterface

// Configuration write channel
interface tcw_cfg_if import tcw_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// Text console writer: a 25 x 80 character screen with its own cursor.
// req carries one operation per transaction: a put of one character byte or a
// read of one screen cell. rsp returns one transaction per request with the
// cursor after the operation and, for a read, the cell's character and attribute.
// cfg writes the background (index 0) and foreground (index 1) colors; it is
// always ready and should be written only while no request is in flight.
// A small microprogram walks each request through a fetch step, any work steps
// on the screen store (one write port, one registered read port), and an emit
// step that loads the response register. The sequencer then returns to the fetch
// step, so the next request can be taken while the response may still wait in its
// register. An ignored byte goes straight to the emit step; a tab makes up to four
// space writes; a newline on the bottom row scrolls, blanking one 80-cell row at
// one store write per cycle (rows are addressed through a rotating base).
// After rst the block sweeps all 2000 cells to blank, one per cycle, and takes
// no request until the sweep is done; cfg writes are taken throughout.
// A stalled rsp holds the sequencer in its emit step; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tcw_req_if.sink    req,
  tcw_rsp_if.source  rsp,
  tcw_cfg_if.sink    cfg
);

  // Sequencer and datapath registers
  upc_t                 upc;
  upc_t                 upc_next;
  logic [ADDR_W-1:0]    sweep;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     base;
  logic [ROW_W-1:0]     blank_row;
  logic [TAB_CNT_W-1:0] tab_cnt;
  logic [BG_W-1:0]      bg;
  logic [FG_W-1:0]      fg;

  // Latched request
  logic              is_read;
  logic              read_ok;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  rr_q;
  logic [COL_W-1:0]  rc_q;

  // Response register
  logic              out_valid;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic [CHAR_W-1:0] out_char;
  logic [CHAR_W-1:0] out_attr;

  // Screen store
  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [CELL_W-1:0] rd_data;

  // Control
  uop_t              uop;
  logic              cond_hit;
  logic              req_ready;
  logic              req_fire;
  logic              out_free;
  logic              out_load;
  logic              put_ok;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ROW_W-1:0]  cur_phys;
  logic [ROW_W-1:0]  read_phys;
  logic [CHAR_W-1:0] attr;

  // Map a screen row to a store row through the rotating base
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lr,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] s;
    s = {1'b0, lr} + {1'b0, b};
    if (s >= (ROW_W + 1)'(ROWS)) begin
      s = s - (ROW_W + 1)'(ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  // Entry step for a newly accepted request
  function automatic upc_t dispatch(input logic op, input logic [CHAR_W-1:0] ch);
    upc_t t;
    if (op == OP_READ) begin
      t = U_READ;
    end else if (ch >= SPACE_CODE && ch <= LAST_PRINTABLE) begin
      t = U_PUT;
    end else if (ch == NEWLINE_CODE) begin
      t = U_NEWLINE;
    end else if (ch == TAB_CODE) begin
      t = U_TAB;
    end else if (ch == BACKSPACE_CODE) begin
      t = U_BACKSPACE;
    end else begin
      t = U_EMIT;
    end
    return t;
  endfunction

  assign attr      = {1'b0, bg, fg};
  assign cur_phys  = phys_row(row, base);
  assign read_phys = phys_row(rr_q, base);
  assign req_fire  = req.valid && req_ready;
  assign out_free  = !out_valid || rsp.ready;
  assign put_ok    = (col != COL_W'(COLUMNS - 1));
  assign mem_raddr = cell_addr(read_phys, rc_q);

  assign req.ready      = req_ready;
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = out_valid;
  assign rsp.cursor_row = out_row;
  assign rsp.cursor_col = out_col;
  assign rsp.cell_char  = out_char;
  assign rsp.cell_attr  = out_attr;

  // Step register
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_CLEAR;
    end else begin
      upc <= upc_next;
    end
  end

  // Decode the control word into datapath strobes and the next step
  always_comb begin
    uop       = ucode(upc);
    cond_hit  = 1'b0;
    req_ready = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;

    unique case (uop.act)
      A_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = RESET_BLANK;
      end
      A_FETCH: begin
        req_ready = 1'b1;
      end
      A_READ: begin
        mem_re = read_ok;
      end
      A_PUT: begin
        mem_we    = put_ok;
        mem_waddr = cell_addr(cur_phys, col);
        mem_wdata = {attr, char_q};
      end
      A_TAB: begin
        mem_we    = put_ok;
        mem_waddr = cell_addr(cur_phys, col);
        mem_wdata = {attr, SPACE_CODE};
      end
      A_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = cell_addr(blank_row, sweep[COL_W-1:0]);
        mem_wdata = {attr, SPACE_CODE};
      end
      A_BACKSPACE: begin
        mem_we    = (col != '0);
        mem_waddr = cell_addr(cur_phys, col - 1'b1);
        mem_wdata = {attr, SPACE_CODE};
      end
      A_EMIT: begin
        out_load = out_free;
      end
      default: ;
    endcase

    unique case (uop.cond)
      C_TRUE:       cond_hit = 1'b1;
      C_CLEAR_LAST: cond_hit = (sweep == ADDR_W'(CELL_COUNT - 1));
      C_ROW_LAST:   cond_hit = (sweep == ADDR_W'(COLUMNS - 1));
      C_TAB_LAST:   cond_hit = (tab_cnt == '0);
      C_SCROLL:     cond_hit = (row == ROW_W'(ROWS - 1));
      C_OUT_FREE:   cond_hit = out_free;
      default:      cond_hit = 1'b0;
    endcase

    if (uop.cond == C_DISPATCH) begin
      upc_next = req_fire ? dispatch(req.opcode, req.char_code) : U_FETCH;
    end else begin
      upc_next = cond_hit ? uop.jt : uop.jf;
    end
  end

  // Cursor, scroll base, sweep counter, colors and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep     <= '0;
      row       <= '0;
      col       <= '0;
      base      <= '0;
      out_valid <= 1'b0;
      bg        <= BG_RESET;
      fg        <= FG_RESET;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_BACKGROUND: bg <= cfg.data[BG_W-1:0];
          REG_FOREGROUND: fg <= cfg.data[FG_W-1:0];
          default: ;
        endcase
      end

      case (uop.act) inside
        A_CLEAR, A_BLANK: begin
          sweep <= cond_hit ? '0 : sweep + 1'b1;
        end
        A_PUT, A_TAB: begin
          if (put_ok) begin
            col <= col + 1'b1;
          end
        end
        A_NEWLINE: begin
          col <= '0;
          if (row == ROW_W'(ROWS - 1)) begin
            base <= (base == ROW_W'(ROWS - 1)) ? '0 : base + 1'b1;
          end else begin
            row <= row + 1'b1;
          end
        end
        A_BACKSPACE: begin
          if (col != '0) begin
            col <= col - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Request latch, tab counter, scroll row and response payload
  always_ff @(posedge clk) begin
    if (req_fire) begin
      is_read <= (req.opcode == OP_READ);
      read_ok <= (req.read_row < ROW_W'(ROWS)) && (req.read_col < COL_W'(COLUMNS));
      char_q  <= req.char_code;
      rr_q    <= req.read_row;
      rc_q    <= req.read_col;
      tab_cnt <= TAB_CNT_W'(TAB_WIDTH - 1);
    end else if (uop.act == A_TAB) begin
      tab_cnt <= tab_cnt - 1'b1;
    end

    // The row leaving the top becomes the new bottom row
    if (uop.act == A_NEWLINE) begin
      blank_row <= base;
    end

    if (out_load) begin
      out_row <= row;
      out_col <= col;
      if (is_read && read_ok) begin
        out_char <= rd_data[CHAR_W-1:0];
        out_attr <= rd_data[CELL_W-1:CHAR_W];
      end else begin
        out_char <= '0;
        out_attr <= '0;
      end
    end
  end

  // Screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data <= screen[mem_raddr];
    end
  end

  // Checks
  `TCW_ASSERT_NOW(a_wr_in_range, mem_we, mem_waddr < ADDR_W'(CELL_COUNT), "store write out of range")
  `TCW_ASSERT_NOW(a_cursor_range, req.valid || !req.valid, (row < ROW_W'(ROWS)) && (col < COL_W'(COLUMNS)) && (base < ROW_W'(ROWS)), "cursor or base out of range")
  `TCW_ASSERT_NEXT(a_emit_shows, out_load, rsp.valid && (rsp.cursor_row == $past(row)), "response not presented")
  `TCW_ASSERT_NOW(a_no_take_in_clear, upc == U_CLEAR, !req.ready && mem_we, "request taken during clear")

endmodule

`default_nettype wire

// ----- sim/console_screen_check.sv -----
`timescale 1ns / 1ps

module console_screen_check import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  tcw_req_if   req,
  tcw_rsp_if   rsp,
  tcw_cfg_if   cfg,
  output int   fails,
  output int   waiting
);

  typedef struct packed {
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } cursor_cell_t;

  // Mirror of the screen, the cursor and the color registers
  logic [CELL_W-1:0] screen [CELL_COUNT];
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [BG_W-1:0]   bg;
  logic [FG_W-1:0]   fg;

  cursor_cell_t expected_echoes [$];
  cursor_cell_t want;
  cursor_cell_t got;
  logic [CELL_W-1:0] stored;

  function automatic logic [CELL_W-1:0] tinted(input logic [CHAR_W-1:0] ch);
    return {1'b0, bg, fg, ch};
  endfunction

  task automatic report_mismatch(input string what, input int seen, input int wanted);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, seen, wanted);
    fails++;
  endtask

  // Store a glyph at the cursor and advance, unless parked in the last column
  task automatic place_glyph(input logic [CHAR_W-1:0] ch);
    if (cur_col != COLUMNS - 1) begin
      screen[cur_row * COLUMNS + cur_col] = tinted(ch);
      cur_col++;
    end
  endtask

  // Shift every row up by one and blank the bottom row
  task automatic scroll_screen();
    for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
      screen[i] = screen[i + COLUMNS];
    for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
      screen[i] = tinted(SPACE_CODE);
  endtask

  task automatic apply_byte(input logic [CHAR_W-1:0] ch);
    if (ch >= SPACE_CODE && ch <= LAST_PRINTABLE) begin
      place_glyph(ch);
    end else if (ch == NEWLINE_CODE) begin
      if (cur_row >= ROWS - 1) begin
        scroll_screen();
        cur_row = ROWS - 1;
      end else begin
        cur_row++;
      end
      cur_col = 0;
    end else if (ch == TAB_CODE) begin
      repeat (TAB_WIDTH) place_glyph(SPACE_CODE);
    end else if (ch == BACKSPACE_CODE) begin
      if (cur_col != 0) begin
        cur_col--;
        screen[cur_row * COLUMNS + cur_col] = tinted(SPACE_CODE);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELL_COUNT; i++)
        screen[i] = RESET_BLANK;
      cur_row = '0;
      cur_col = '0;
      bg = BG_RESET;
      fg = FG_RESET;
      expected_echoes.delete();
    end else begin
      // Track color register writes
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_BACKGROUND)
          bg = cfg.data[BG_W-1:0];
        else if (cfg.index == REG_FOREGROUND)
          fg = cfg.data[FG_W-1:0];
      end

      // Predict the response of each accepted request
      if (req.valid && req.ready) begin
        want.cell_char = '0;
        want.cell_attr = '0;
        if (req.opcode == OP_PUT) begin
          apply_byte(req.char_code);
        end else if (req.read_row < ROWS && req.read_col < COLUMNS) begin
          stored = screen[req.read_row * COLUMNS + req.read_col];
          want.cell_char = stored[7:0];
          want.cell_attr = stored[15:8];
        end
        want.cursor_row = cur_row;
        want.cursor_col = cur_col;
        expected_echoes.push_back(want);
      end

      // Compare each response against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.cursor_row, rsp.cursor_col, rsp.cell_char, rsp.cell_attr};
        if (expected_echoes.size() == 0) begin
          report_mismatch("unexpected response, cursor_col", got.cursor_col, -1);
        end else begin
          want = expected_echoes.pop_front();
          if (got.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", got.cursor_row, want.cursor_row);
          if (got.cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", got.cursor_col, want.cursor_col);
          if (got.cell_char !== want.cell_char)
            report_mismatch("cell_char", got.cell_char, want.cell_char);
          if (got.cell_attr !== want.cell_attr)
            report_mismatch("cell_attr", got.cell_attr, want.cell_attr);
        end
      end
    end
    waiting <= expected_echoes.size();
  end

endmodule

// ----- sim/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst;
  int   fails;
  int   waiting;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  logic pressure_arm;
  logic pressure_done;
  int   quiet_cycles;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();
  tcw_cfg_if cfg_ch ();

  text_console_writer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  console_screen_check check (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .waiting (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Response side: random back-pressure, plus one long hold when armed
  initial begin
    rsp_ch.ready = 1'b0;
    pressure_done = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_arm && !pressure_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Abort when no transaction moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request, with random gaps ahead of it, and hold until taken
  task automatic send_op(input logic op, input logic [CHAR_W-1:0] ch,
                         input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.opcode    <= op;
    req_ch.char_code <= ch;
    req_ch.read_row  <= row;
    req_ch.read_col  <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_op(OP_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_at(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_op(OP_READ, CHAR_W'($urandom), row, col);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_colors(input logic [BG_W-1:0] bg, input logic [FG_W-1:0] fg);
    cfg_write(REG_BACKGROUND, CFG_DATA_W'(bg));
    cfg_write(REG_FOREGROUND, fg);
    cfg_ch.valid <= 1'b0;
  endtask

  // Drop the request and wait for every response to come back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // Random text: mostly printable runs and line breaks, plus tabs, backspaces, ignored bytes and reads,
  // with long lines to reach the last column and enough newlines to keep the screen scrolling
  task automatic send_random_text(input int count);
    int run_left;
    int pick;
    logic [CHAR_W-1:0] ch;
    run_left = 0;
    repeat (count) begin
      if (run_left > 0) begin
        run_left--;
        if ($urandom_range(9) == 0)
          put_char(TAB_CODE);
        else
          put_char(CHAR_W'($urandom_range(SPACE_CODE, LAST_PRINTABLE)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          run_left = $urandom_range(70, 95);
          put_char(CHAR_W'($urandom_range(SPACE_CODE, LAST_PRINTABLE)));
        end else if (pick < 50) begin
          put_char(CHAR_W'($urandom_range(SPACE_CODE, LAST_PRINTABLE)));
        end else if (pick < 60) begin
          put_char(NEWLINE_CODE);
        end else if (pick < 65) begin
          put_char(TAB_CODE);
        end else if (pick < 71) begin
          put_char(BACKSPACE_CODE);
        end else if (pick < 77) begin
          if ($urandom_range(1) == 0) begin
            do ch = CHAR_W'($urandom_range(SPACE_CODE - 1));
            while (ch == NEWLINE_CODE || ch == TAB_CODE || ch == BACKSPACE_CODE);
          end else begin
            ch = CHAR_W'($urandom_range(LAST_PRINTABLE + 1, 255));
          end
          put_char(ch);
        end else if (pick < 95) begin
          read_at(ROW_W'($urandom_range(ROWS - 1)), COL_W'($urandom_range(COLUMNS - 1)));
        end else begin
          read_at(ROW_W'($urandom), COL_W'($urandom));
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    pressure_arm = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_PUT;
    req_ch.char_code = '0;
    req_ch.read_row = '0;
    req_ch.read_col = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_BACKGROUND;
    cfg_ch.data = '0;
    set_idling(6, 70);
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset colors, field extremes, each control byte
    read_at(ROW_W'(0), COL_W'(0));
    put_char(BACKSPACE_CODE);
    put_char(8'd65);
    put_char(SPACE_CODE);
    put_char(LAST_PRINTABLE);
    put_char(LAST_PRINTABLE + 8'd1);
    put_char(SPACE_CODE - 8'd1);
    put_char(8'd0);
    put_char(8'd255);
    put_char(8'd13);
    put_char(8'd128);
    put_char(TAB_CODE);
    read_at(ROW_W'(0), COL_W'(1));
    put_char(BACKSPACE_CODE);
    read_at(ROW_W'(0), COL_W'(6));
    read_at(ROW_W'(0), COL_W'(3));
    put_char(NEWLINE_CODE);
    read_at(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    read_at(5'd31, 7'd127);
    read_at(ROW_W'(ROWS), COL_W'(0));
    read_at(ROW_W'(0), COL_W'(COLUMNS));
    settle();

    // Random phases across color settings and idling patterns
    set_colors(BG_W'(0), FG_W'(0));
    send_random_text(260);
    settle();

    set_colors(BG_W'(7), FG_W'(15));
    set_idling(70, 6);
    send_random_text(260);
    settle();

    set_colors(BG_W'($urandom), FG_W'($urandom));
    set_idling(0, 0);
    pressure_arm = 1'b1;
    send_random_text(260);
    settle();

    set_colors(BG_W'(7), FG_W'(0));
    send_random_text(250);
    settle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_channels.sv
rtl/text_console_writer.sv
sim/console_screen_check.sv
sim/text_console_writer_tb.sv
